@@ hdl/pfhd_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pfhd_pkg
// shared constants and types for the pcm sample fifo and pwm duty scaler
// ----------------------------------------------------------------------------
package pfhd_pkg;

   localparam int unsigned DEPTH = 4096;
   localparam int unsigned PTR_W = $clog2(DEPTH);
   localparam int unsigned LEVEL_W = 13;
   localparam int unsigned SAMPLE_W = 16;
   localparam int unsigned PERIOD_W = 16;
   localparam int unsigned THRESH_W = 13;
   localparam int unsigned CSR_ADDR_W = 4;
   localparam int unsigned CSR_DATA_W = 16;

   localparam logic [SAMPLE_W-1:0] DUMMY_WORD = 16'hFFFF;
   localparam logic [PERIOD_W-1:0] PERIOD_RESET = 16'd512;
   localparam logic [THRESH_W-1:0] THRESH_RESET = 13'd4046;

   localparam logic CMD_RECEIVE = 1'b0;
   localparam logic CMD_TICK = 1'b1;

   localparam logic [CSR_ADDR_W-1:0] CSR_PWM_PERIOD = 4'd0;
   localparam logic [CSR_ADDR_W-1:0] CSR_REFILL_THRESHOLD = 4'd1;

   localparam logic [LEVEL_W-1:0] LEVEL_FULL = LEVEL_W'(DEPTH);
   localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);

   typedef logic [PTR_W-1:0] ptr_type;
   typedef logic [LEVEL_W-1:0] level_type;
   typedef logic [SAMPLE_W-1:0] sample_type;

   typedef struct packed {
      logic [PERIOD_W-1:0] pwm_period;
      logic [THRESH_W-1:0] refill_threshold;
   } cfg_type;

   // item status carried from the accept stage to the output stage
   typedef struct packed {
      logic request_more;
      logic overflow;
      logic duty_valid;
      level_type fill_level;
   } stage_type;

endpackage

@@ hdl/pfhd_req_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pfhd_req_if
// input channel: received serial words and sample-rate ticks
// ----------------------------------------------------------------------------
interface pfhd_req_if
   import pfhd_pkg::*;
   ();
   logic valid;
   logic ready;
   logic cmd;
   logic [SAMPLE_W-1:0] sample_word;

   modport source (output valid, output cmd, output sample_word, input ready);
   modport sink (input valid, input cmd, input sample_word, output ready);
endinterface

@@ hdl/pfhd_rsp_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pfhd_rsp_if
// result channel: flow-control reply, pwm compares and fill level
// ----------------------------------------------------------------------------
interface pfhd_rsp_if
   import pfhd_pkg::*;
   ();
   logic valid;
   logic ready;
   logic request_more;
   logic overflow;
   logic duty_valid;
   logic [15:0] coarse_compare;
   logic [15:0] fine_compare;
   logic [LEVEL_W-1:0] fill_level;

   modport source (output valid, output request_more, output overflow,
                   output duty_valid, output coarse_compare, output fine_compare,
                   output fill_level, input ready);
   modport sink (input valid, input request_more, input overflow,
                 input duty_valid, input coarse_compare, input fine_compare,
                 input fill_level, output ready);
endinterface

@@ hdl/pfhd_csr_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pfhd_csr_if
// configuration write channel
// ----------------------------------------------------------------------------
interface pfhd_csr_if
   import pfhd_pkg::*;
   ();
   logic valid;
   logic ready;
   logic [CSR_ADDR_W-1:0] addr;
   logic [CSR_DATA_W-1:0] wdata;

   modport source (output valid, output addr, output wdata, input ready);
   modport sink (input valid, input addr, input wdata, output ready);
endinterface

@@ hdl/pfhd_ram.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pfhd_ram
// simple dual-port ram, one write and one registered read port
// ----------------------------------------------------------------------------
module pfhd_ram #(
   parameter int unsigned ADDR_W = 12,
   parameter int unsigned DATA_W = 16
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [DATA_W-1:0] wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [DATA_W-1:0] rd_data
);
   logic [DATA_W-1:0] mem [(1 << ADDR_W)];
   logic [DATA_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;
endmodule

@@ hdl/pfhd_csr.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pfhd_csr
// configuration registers: pwm period and refill threshold
// ----------------------------------------------------------------------------
module pfhd_csr
   import pfhd_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   pfhd_csr_if.sink csr_chan,
   output cfg_type cfg
);
   cfg_type cfg_ff;
   cfg_type cfg_in;

   assign csr_chan.ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_chan.valid) begin
         case (csr_chan.addr)
            CSR_PWM_PERIOD: begin
               cfg_in.pwm_period = csr_chan.wdata[PERIOD_W-1:0];
            end
            CSR_REFILL_THRESHOLD: begin
               cfg_in.refill_threshold = csr_chan.wdata[THRESH_W-1:0];
            end
            default: begin
               cfg_in = cfg_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.pwm_period <= PERIOD_RESET;
         cfg_ff.refill_threshold <= THRESH_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;
endmodule

@@ hdl/pfhd_ctrl.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pfhd_ctrl
// accept stage: pointers, fill level, store access and reply flags
// ----------------------------------------------------------------------------
module pfhd_ctrl
   import pfhd_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   pfhd_req_if.sink   req_chan,
   input  cfg_type    cfg,
   input  logic       advance,
   output logic       mem_wr_en,
   output ptr_type    mem_wr_addr,
   output sample_type mem_wr_data,
   output logic       mem_rd_en,
   output ptr_type    mem_rd_addr,
   output logic       stage_valid,
   output stage_type  stage
);
   ptr_type   rd_ptr_ff, rd_ptr_in;
   ptr_type   wr_ptr_ff, wr_ptr_in;
   level_type level_ff, level_in;
   logic      stage_valid_ff, stage_valid_in;
   stage_type stage_ff, stage_in;

   logic accept;
   logic is_store;
   logic is_full;
   logic do_write;
   logic do_read;

   // the stage slot frees as soon as its item moves on
   assign req_chan.ready = !stage_valid_ff || advance;
   assign accept = req_chan.valid && req_chan.ready;

   assign is_store = (req_chan.cmd == CMD_RECEIVE) && (req_chan.sample_word != DUMMY_WORD);
   assign is_full = (level_ff == LEVEL_FULL);
   assign do_write = accept && is_store && !is_full;
   assign do_read = accept && (req_chan.cmd == CMD_TICK) && (level_ff != '0);

   always_comb begin
      rd_ptr_in = rd_ptr_ff;
      wr_ptr_in = wr_ptr_ff;
      level_in = level_ff;
      if (do_write) begin
         wr_ptr_in = (wr_ptr_ff == PTR_LAST) ? '0 : wr_ptr_ff + 1'b1;
         level_in = level_ff + 1'b1;
      end
      if (do_read) begin
         rd_ptr_in = (rd_ptr_ff == PTR_LAST) ? '0 : rd_ptr_ff + 1'b1;
         level_in = level_ff - 1'b1;
      end
   end

   always_comb begin
      stage_valid_in = stage_valid_ff;
      stage_in = stage_ff;
      if (advance) begin
         stage_valid_in = 1'b0;
      end
      if (accept) begin
         stage_valid_in = 1'b1;
         stage_in.request_more = (req_chan.cmd == CMD_RECEIVE)
                                 && (level_in < cfg.refill_threshold);
         stage_in.overflow = is_store && is_full;
         stage_in.duty_valid = do_read;
         stage_in.fill_level = level_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_ptr_ff <= '0;
         wr_ptr_ff <= '0;
         level_ff <= '0;
         stage_valid_ff <= 1'b0;
      end else begin
         rd_ptr_ff <= rd_ptr_in;
         wr_ptr_ff <= wr_ptr_in;
         level_ff <= level_in;
         stage_valid_ff <= stage_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      stage_ff <= stage_in;
   end

   // writes land at accept, so a later pop of the entry always reads it back
   assign mem_wr_en = do_write;
   assign mem_wr_addr = wr_ptr_ff;
   assign mem_wr_data = req_chan.sample_word;
   assign mem_rd_en = do_read;
   assign mem_rd_addr = rd_ptr_ff;
   assign stage_valid = stage_valid_ff;
   assign stage = stage_ff;
endmodule

@@ hdl/pfhd_out.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pfhd_out
// output stage: scales the popped sample by the period, holds the result
// ----------------------------------------------------------------------------
module pfhd_out
   import pfhd_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  cfg_type    cfg,
   input  logic       stage_valid,
   input  stage_type  stage,
   input  sample_type rd_data,
   output logic       advance,
   pfhd_rsp_if.source rsp_chan
);
   logic        rsp_valid_ff, rsp_valid_in;
   stage_type   res_ff;
   logic [15:0] coarse_ff, coarse_in;
   logic [15:0] fine_ff, fine_in;
   logic [SAMPLE_W+PERIOD_W-1:0] product;

   assign advance = !rsp_valid_ff || rsp_chan.ready;

   assign product = rd_data * cfg.pwm_period;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      coarse_in = coarse_ff;
      fine_in = fine_ff;
      if (advance) begin
         rsp_valid_in = stage_valid;
         coarse_in = stage.duty_valid ? product[31:16] : 16'd0;
         fine_in = stage.duty_valid ? product[15:0] : 16'd0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      coarse_ff <= coarse_in;
      fine_ff <= fine_in;
      if (advance) begin
         res_ff <= stage;
      end
   end

   assign rsp_chan.valid = rsp_valid_ff;
   assign rsp_chan.request_more = res_ff.request_more;
   assign rsp_chan.overflow = res_ff.overflow;
   assign rsp_chan.duty_valid = res_ff.duty_valid;
   assign rsp_chan.fill_level = res_ff.fill_level;
   assign rsp_chan.coarse_compare = coarse_ff;
   assign rsp_chan.fine_compare = fine_ff;
endmodule

@@ hdl/pcm_fifo_to_hrpwm_duty.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pcm_fifo_to_hrpwm_duty
// path: accept stage register, then output stage register; one item per
//    cycle while results are taken, set by one write and one read port on
//    the sample ram and a single 16x16 multiply in the output stage
// reset: pointers, fill level and handshake state clear, pwm period 512 and
//    refill threshold 4046; the sample ram is not cleared, no clearing pass
// ----------------------------------------------------------------------------
module pcm_fifo_to_hrpwm_duty
   import pfhd_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   pfhd_req_if.sink   req_chan,
   pfhd_rsp_if.source rsp_chan,
   pfhd_csr_if.sink   csr_chan
);
   cfg_type    cfg;
   logic       advance;
   logic       mem_wr_en;
   ptr_type    mem_wr_addr;
   sample_type mem_wr_data;
   logic       mem_rd_en;
   ptr_type    mem_rd_addr;
   sample_type mem_rd_data;
   logic       stage_valid;
   stage_type  stage;

   pfhd_csr u_csr (
      .clock    (clock),
      .reset    (reset),
      .csr_chan (csr_chan),
      .cfg      (cfg)
   );

   pfhd_ctrl u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_chan    (req_chan),
      .cfg         (cfg),
      .advance     (advance),
      .mem_wr_en   (mem_wr_en),
      .mem_wr_addr (mem_wr_addr),
      .mem_wr_data (mem_wr_data),
      .mem_rd_en   (mem_rd_en),
      .mem_rd_addr (mem_rd_addr),
      .stage_valid (stage_valid),
      .stage       (stage)
   );

   pfhd_ram #(
      .ADDR_W (PTR_W),
      .DATA_W (SAMPLE_W)
   ) u_ram (
      .clock   (clock),
      .wr_en   (mem_wr_en),
      .wr_addr (mem_wr_addr),
      .wr_data (mem_wr_data),
      .rd_en   (mem_rd_en),
      .rd_addr (mem_rd_addr),
      .rd_data (mem_rd_data)
   );

   pfhd_out u_out (
      .clock       (clock),
      .reset       (reset),
      .cfg         (cfg),
      .stage_valid (stage_valid),
      .stage       (stage),
      .rd_data     (mem_rd_data),
      .advance     (advance),
      .rsp_chan    (rsp_chan)
   );
endmodule
